@@ hdl/pcrc_pkg.sv @@
// shared types, item codes and crc-32k functions for the packet crc generator
`default_nettype none

package pcrc_pkg;

   localparam logic [2:0] KIND_REQ_HEADER = 3'd0;
   localparam logic [2:0] KIND_RSP_HEADER = 3'd1;
   localparam logic [2:0] KIND_DATA       = 3'd2;
   localparam logic [2:0] KIND_REQ_TAIL   = 3'd3;
   localparam logic [2:0] KIND_RSP_TAIL   = 3'd4;

   localparam logic [31:0] CRC_POLY = 32'hEB31D82E;
   localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

   localparam int REQ_DATA_W = 128;
   localparam int KIND_W     = 3;
   localparam int WORD_W     = 64;
   localparam int CRC_W      = 32;

   typedef struct packed {
      logic                valid;
      logic [KIND_W-1:0]   kind;
      logic [WORD_W-1:0]   word;
   } stage_type;

   function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                 input logic [7:0] data_byte);
      logic [CRC_W-1:0] r;
      r = crc ^ {24'd0, data_byte};
      for (int k = 0; k < 8; k++) begin
         if (r[0]) begin
            r = (r >> 1) ^ CRC_POLY;
         end else begin
            r = r >> 1;
         end
      end
      return r;
   endfunction

   function automatic logic [CRC_W-1:0] crc_word(input logic [CRC_W-1:0] crc,
                                                 input logic [WORD_W-1:0] word);
      logic [CRC_W-1:0] r;
      r = crc;
      for (int b = 0; b < 8; b++) begin
         r = crc_byte(r, word[b*8 +: 8]);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

@@ hdl/packet_crc32k_generator.sv @@
// top level: link packet crc-32k generator over 64-bit words
// a tail is held in the input register, then its crc in the result register (rsp_tvalid)
// throughput: one request per cycle, as the 64-bit crc update is combinational;
// a stalled result holds back a tail in the input register and every request behind it
// synchronous reset clears both stages and loads the running crc with all ones
`default_nettype none

module packet_crc32k_generator
   import pcrc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // data_word[63:0] cube_id[66:64] tag[77:67] length[82:78] command[89:83]
   // status_field[96:90] flag_bit[97] retry_count[100:98] seq[103:101]
   // forward_pointer[112:104] return_pointer[121:113] zero[127:122]
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // req_type[2:0]
   input  wire logic [KIND_W-1:0]     req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // crc[31:0]
   output logic [CRC_W-1:0]           rsp_tdata
);

   stage_type stage;
   logic      advance;

   pcrc_input_stage u_input (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .advance    (advance),
      .stage      (stage)
   );

   pcrc_crc_stage u_crc (
      .clock      (clock),
      .reset      (reset),
      .stage      (stage),
      .advance    (advance),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

@@ hdl/pcrc_input_stage.sv @@
// input register: unpacks a request and forms the 64-bit link word
`default_nettype none

module pcrc_input_stage
   import pcrc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic [KIND_W-1:0]     req_tuser,
   input  wire logic                  advance,
   output stage_type                  stage
);

   stage_type         stage_ff;
   stage_type         stage_in;
   logic [63:0]       data_word;
   logic [2:0]        cube_id;
   logic [10:0]       tag;
   logic [4:0]        length;
   logic [6:0]        command;
   logic [6:0]        status_field;
   logic              flag_bit;
   logic [2:0]        retry_count;
   logic [2:0]        seq;
   logic [8:0]        forward_pointer;
   logic [8:0]        return_pointer;
   logic [63:0]       header_low;
   logic [63:0]       tail_low;
   logic [63:0]       packed_word;

   assign data_word       = req_tdata[63:0];
   assign cube_id         = req_tdata[66:64];
   assign tag             = req_tdata[77:67];
   assign length          = req_tdata[82:78];
   assign command         = req_tdata[89:83];
   assign status_field    = req_tdata[96:90];
   assign flag_bit        = req_tdata[97];
   assign retry_count     = req_tdata[100:98];
   assign seq             = req_tdata[103:101];
   assign forward_pointer = req_tdata[112:104];
   assign return_pointer  = req_tdata[121:113];

   assign req_tready = !stage_ff.valid || advance;
   assign stage      = stage_ff;

   always_comb begin
      header_low = {41'd0, tag, length, command};
      tail_low   = {32'd0, retry_count, 7'd0, flag_bit, seq, forward_pointer,
                    return_pointer};
      case (req_tuser)
         KIND_REQ_HEADER: packed_word = {cube_id, 3'd0, data_word[33:0], 24'd0}
                                        | header_low;
         KIND_RSP_HEADER: packed_word = {cube_id, 19'd0, status_field[2:0], 5'd0,
                                         flag_bit, 33'd0} | header_low;
         KIND_REQ_TAIL:   packed_word = tail_low
                                        | {35'd0, status_field[2:0], 26'd0};
         KIND_RSP_TAIL:   packed_word = tail_low | {35'd0, status_field, 22'd0};
         default:         packed_word = data_word;
      endcase
   end

   always_comb begin
      stage_in       = stage_ff;
      stage_in.valid = stage_ff.valid && !advance;
      if (req_tvalid && req_tready) begin
         stage_in.valid = 1'b1;
         stage_in.kind  = req_tuser;
         stage_in.word  = packed_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else begin
         stage_ff.valid <= stage_in.valid;
      end
      stage_ff.kind <= stage_in.kind;
      stage_ff.word <= stage_in.word;
   end

endmodule

`default_nettype wire

@@ hdl/pcrc_crc_stage.sv @@
// running crc-32k register and result register
`default_nettype none

module pcrc_crc_stage
   import pcrc_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire stage_type        stage,
   output logic                  advance,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output logic [CRC_W-1:0]      rsp_tdata
);

   logic [CRC_W-1:0] running_crc_ff;
   logic [CRC_W-1:0] running_crc_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic [CRC_W-1:0] rsp_data_ff;
   logic [CRC_W-1:0] rsp_data_in;
   logic             is_tail;
   logic             is_known;

   assign is_tail  = (stage.kind == KIND_REQ_TAIL) || (stage.kind == KIND_RSP_TAIL);
   assign is_known = is_tail || (stage.kind == KIND_DATA)
                     || (stage.kind == KIND_REQ_HEADER) || (stage.kind == KIND_RSP_HEADER);
   assign advance  = stage.valid && (!is_tail || !rsp_valid_ff || rsp_tready);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      running_crc_in = running_crc_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_data_in    = rsp_data_ff;
      if (advance) begin
         case (stage.kind)
            KIND_REQ_HEADER,
            KIND_RSP_HEADER: running_crc_in = crc_word(CRC_INIT, stage.word);
            KIND_DATA:       running_crc_in = crc_word(running_crc_ff, stage.word);
            KIND_REQ_TAIL,
            KIND_RSP_TAIL: begin
               rsp_data_in    = ~crc_word(running_crc_ff, stage.word);
               rsp_valid_in   = 1'b1;
               running_crc_in = CRC_INIT;
            end
            default: begin
               running_crc_in = running_crc_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_crc_ff <= CRC_INIT;
         rsp_valid_ff   <= 1'b0;
      end else begin
         running_crc_ff <= running_crc_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   a_tail_restarts: assert property (@(posedge clock) disable iff (reset)
      advance && is_tail |=> running_crc_ff == CRC_INIT)
      else $error("crc not restarted after tail");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready && stage.valid && is_tail |-> !advance)
      else $error("pending result overwritten");

   a_unknown_kind_idle: assert property (@(posedge clock) disable iff (reset)
      advance && !is_known |=> $stable(running_crc_ff))
      else $error("unknown item changed crc");

   a_tail_gives_result: assert property (@(posedge clock) disable iff (reset)
      advance && is_tail |=> rsp_valid_ff)
      else $error("tail gave no result");

endmodule

`default_nettype wire

@@ tb/tb_packet_crc32k_generator.sv @@
// testbench for the link packet crc-32k generator: directed and random packets, checked per tail
module tb_packet_crc32k_generator;
   import pcrc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int PHASE_ITEMS  = 100;
   localparam int FILL_ZERO    = 0;
   localparam int FILL_ONES    = 1;
   localparam int FILL_RANDOM  = 2;
   localparam logic [2:0] KIND_UNUSED_LO = 3'd5;
   localparam logic [2:0] KIND_UNUSED_HI = 3'd7;

   typedef struct {
      logic [KIND_W-1:0] kind;
      logic [63:0]       word;
      logic [2:0]        cube;
      logic [10:0]       tag;
      logic [4:0]        len;
      logic [6:0]        cmd;
      logic [6:0]        status;
      logic              flag;
      logic [2:0]        retry;
      logic [2:0]        seq;
      logic [8:0]        fwd;
      logic [8:0]        ret;
   } request_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [KIND_W-1:0]     req_tuser  = KIND_DATA;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b1;
   logic [CRC_W-1:0]      rsp_tdata;

   logic [CRC_W-1:0] crc_running;
   logic [CRC_W-1:0] crc_expected[$];
   int idle_pct       = 0;
   int stall_pct      = 0;
   int requests_sent  = 0;
   int ignored_seen   = 0;
   int crcs_checked   = 0;
   int packets_sent   = 0;
   int failures       = 0;
   int cycle_count    = 0;

   packet_crc32k_generator u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("simulation failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
   end

   // reflected crc-32k, shifted in one bit at a time from bit 0 upward
   function automatic logic [CRC_W-1:0] crc32k_feed(input logic [CRC_W-1:0] crc,
                                                    input logic [63:0] word);
      logic [CRC_W-1:0] r;
      logic             fb;
      r = crc;
      for (int i = 0; i < 64; i++) begin
         fb = r[0] ^ word[i];
         r  = r >> 1;
         if (fb) begin
            r = r ^ CRC_POLY;
         end
      end
      return r;
   endfunction

   function automatic logic [63:0] link_word(input logic [KIND_W-1:0] kind,
                                             input logic [REQ_DATA_W-1:0] d);
      case (kind)
         KIND_REQ_HEADER: begin
            return {d[66:64], 3'd0, d[33:0], 1'b0, d[77:67], d[82:78], d[89:83]};
         end
         KIND_RSP_HEADER: begin
            return {d[66:64], 19'd0, d[92:90], 5'd0, d[97], 10'd0,
                    d[77:67], d[82:78], d[89:83]};
         end
         KIND_REQ_TAIL: begin
            return {32'd0, d[100:98], d[92:90], 4'd0, d[97], d[103:101],
                    d[112:104], d[121:113]};
         end
         KIND_RSP_TAIL: begin
            return {32'd0, d[100:98], d[96:90], d[97], d[103:101],
                    d[112:104], d[121:113]};
         end
         default: begin
            return d[63:0];
         end
      endcase
   endfunction

   always @(posedge clock) begin : packet_crc_predictor
      logic [63:0] w;
      if (reset) begin
         crc_running = CRC_INIT;
      end else if (req_tvalid && req_tready) begin
         w = link_word(req_tuser, req_tdata);
         case (req_tuser)
            KIND_REQ_HEADER, KIND_RSP_HEADER: begin
               crc_running = crc32k_feed(CRC_INIT, w);
            end
            KIND_DATA: begin
               crc_running = crc32k_feed(crc_running, w);
            end
            KIND_REQ_TAIL, KIND_RSP_TAIL: begin
               crc_expected.push_back(~crc32k_feed(crc_running, w));
               crc_running = CRC_INIT;
            end
            default: begin
               ignored_seen++;
            end
         endcase
      end
   end

   always @(posedge clock) begin : packet_crc_checker
      logic [CRC_W-1:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (crc_expected.size() == 0) begin
            if (failures < 10) begin
               $display("unexpected crc %08h at cycle %0d", rsp_tdata, cycle_count);
            end
            failures++;
         end else begin
            want = crc_expected.pop_front();
            crcs_checked++;
            if (rsp_tdata !== want) begin
               if (failures < 10) begin
                  $display("crc mismatch at cycle %0d: expected %08h, got %08h",
                           cycle_count, want, rsp_tdata);
               end
               failures++;
            end
         end
      end
   end

   function automatic request_type make_request(input logic [KIND_W-1:0] kind,
                                                input int fill);
      request_type r;
      r.kind = kind;
      if (fill == FILL_RANDOM) begin
         r.word   = {$urandom, $urandom};
         r.cube   = 3'($urandom);
         r.tag    = 11'($urandom);
         r.len    = 5'($urandom);
         r.cmd    = 7'($urandom);
         r.status = 7'($urandom);
         r.flag   = 1'($urandom);
         r.retry  = 3'($urandom);
         r.seq    = 3'($urandom);
         r.fwd    = 9'($urandom);
         r.ret    = 9'($urandom);
      end else begin
         r.word   = (fill == FILL_ONES) ? '1 : '0;
         r.cube   = (fill == FILL_ONES) ? '1 : '0;
         r.tag    = (fill == FILL_ONES) ? '1 : '0;
         r.len    = (fill == FILL_ONES) ? '1 : '0;
         r.cmd    = (fill == FILL_ONES) ? '1 : '0;
         r.status = (fill == FILL_ONES) ? '1 : '0;
         r.flag   = (fill == FILL_ONES) ? '1 : '0;
         r.retry  = (fill == FILL_ONES) ? '1 : '0;
         r.seq    = (fill == FILL_ONES) ? '1 : '0;
         r.fwd    = (fill == FILL_ONES) ? '1 : '0;
         r.ret    = (fill == FILL_ONES) ? '1 : '0;
      end
      return r;
   endfunction

   task automatic send_request(input request_type r);
      while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= r.kind;
      req_tdata  <= {6'd0, r.ret, r.fwd, r.seq, r.retry, r.flag, r.status,
                     r.cmd, r.len, r.tag, r.cube, r.word};
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      if (r.kind <= KIND_RSP_TAIL) begin
         requests_sent++;
      end
   endtask

   task automatic send_kind(input logic [KIND_W-1:0] kind, input int fill);
      send_request(make_request(kind, fill));
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (crc_expected.size() != 0) begin
         @(posedge clock);
      end
   endtask

   function automatic logic [KIND_W-1:0] unused_kind();
      return KIND_W'($urandom_range(KIND_UNUSED_HI, KIND_UNUSED_LO));
   endfunction

   task automatic send_random_packet();
      int roll;
      int n_data;
      roll = $urandom_range(99);
      if (roll < 85) begin
         send_kind($urandom_range(1) ? KIND_RSP_HEADER : KIND_REQ_HEADER, FILL_RANDOM);
      end else if (roll < 92) begin
         send_kind(unused_kind(), FILL_RANDOM);
      end
      n_data = ($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(4);
      for (int i = 0; i < n_data; i++) begin
         roll = $urandom_range(99);
         if (roll < 3) begin
            send_kind(unused_kind(), FILL_RANDOM);
         end else if (roll < 5) begin
            send_kind($urandom_range(1) ? KIND_RSP_HEADER : KIND_REQ_HEADER, FILL_RANDOM);
         end
         send_kind(KIND_DATA, FILL_RANDOM);
      end
      if ($urandom_range(9) != 0) begin
         send_kind($urandom_range(1) ? KIND_RSP_TAIL : KIND_REQ_TAIL, FILL_RANDOM);
      end
      packets_sent++;
   endtask

   task automatic run_random_phase(input int sender_idle, input int receiver_stall);
      int target;
      idle_pct  = sender_idle;
      stall_pct = receiver_stall;
      target    = requests_sent + PHASE_ITEMS;
      while (requests_sent < target) begin
         send_random_packet();
      end
      wait_drained();
      idle_pct  = 0;
      stall_pct = 0;
   endtask

   task automatic test_directed();
      request_type r;
      // tail with no header runs against the reset value
      send_kind(KIND_REQ_TAIL, FILL_ZERO);
      send_kind(KIND_RSP_TAIL, FILL_ONES);
      send_kind(KIND_REQ_HEADER, FILL_ZERO);
      send_kind(KIND_DATA, FILL_ZERO);
      send_kind(KIND_REQ_TAIL, FILL_ZERO);
      send_kind(KIND_REQ_HEADER, FILL_ONES);
      send_kind(KIND_DATA, FILL_ONES);
      send_kind(KIND_DATA, FILL_ZERO);
      send_kind(KIND_RSP_TAIL, FILL_ONES);
      send_kind(KIND_RSP_HEADER, FILL_ONES);
      send_kind(KIND_DATA, FILL_RANDOM);
      send_kind(KIND_REQ_TAIL, FILL_ONES);
      // unused codes leave the running crc alone
      send_kind(KIND_RSP_HEADER, FILL_ZERO);
      for (int k = KIND_UNUSED_LO; k <= KIND_UNUSED_HI; k++) begin
         send_kind(k[KIND_W-1:0], FILL_RANDOM);
         send_kind(KIND_DATA, FILL_RANDOM);
      end
      send_kind(KIND_RSP_TAIL, FILL_ZERO);
      // header in mid packet restarts the crc
      send_kind(KIND_REQ_HEADER, FILL_RANDOM);
      send_kind(KIND_DATA, FILL_RANDOM);
      r = make_request(KIND_RSP_HEADER, FILL_RANDOM);
      r.status = 7'h78;
      send_request(r);
      send_kind(KIND_DATA, FILL_RANDOM);
      send_kind(KIND_RSP_TAIL, FILL_RANDOM);
      // data after a tail without a new header
      send_kind(KIND_DATA, FILL_ONES);
      send_kind(KIND_REQ_TAIL, FILL_RANDOM);
      send_kind(KIND_RSP_TAIL, FILL_RANDOM);
      wait_drained();
   endtask

   task automatic test_streaming_no_idle();
      run_random_phase(0, 0);
   endtask

   task automatic test_sender_gaps();
      run_random_phase(50, 0);
   endtask

   task automatic test_receiver_stalls();
      run_random_phase(0, 50);
   endtask

   task automatic test_both_sides_idle();
      run_random_phase(6, 6);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_streaming_no_idle();
      test_sender_gaps();
      test_receiver_stalls();
      test_both_sides_idle();
      wait_drained();
      repeat (8) @(posedge clock);
      $display("sent %0d requests in %0d random packets plus directed cases",
               requests_sent, packets_sent);
      $display("checked %0d packet crcs, %0d unused-kind requests ignored, %0d failures",
               crcs_checked, ignored_seen, failures);
      if (failures == 0 && crc_expected.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
